@@ rtl/core/ramrc_pkg.sv @@
// Shared types, constants and node arithmetic for the range add / max run counter.
// No dependencies.
package ramrc_pkg;

  localparam int unsigned DefMaxPositions = 65536;
  localparam int unsigned PosFieldW       = 17;
  localparam int unsigned DeltaW          = 16;
  localparam int unsigned HeightW         = 32;
  localparam int unsigned RunW            = 17;
  localparam int unsigned OutRunW         = 16;

  // One tree node as it sits in the node memory.
  typedef struct packed {
    logic [HeightW-1:0] max_h;
    logic [HeightW-1:0] left_h;
    logic [HeightW-1:0] right_h;
    logic [RunW-1:0]    runs;
    logic [HeightW-1:0] pend;
  } node_rec_t;

  localparam int unsigned NodeRecW = $bits(node_rec_t);

  localparam node_rec_t NodeRecReset = '{
    max_h:   '0,
    left_h:  '0,
    right_h: '0,
    runs:    RunW'(1),
    pend:    '0
  };

  // Add an amount to the heights of a node; pending is left alone.
  function automatic node_rec_t add_rec(node_rec_t rec, logic [HeightW-1:0] amt);
    node_rec_t res;
    res         = rec;
    res.max_h   = rec.max_h + amt;
    res.left_h  = rec.left_h + amt;
    res.right_h = rec.right_h + amt;
    return res;
  endfunction

  // Combine two adjacent children into their parent.
  function automatic node_rec_t merge_rec(node_rec_t lft, node_rec_t rgt);
    node_rec_t       res;
    logic [RunW-1:0] runs;
    res.left_h  = lft.left_h;
    res.right_h = rgt.right_h;
    res.pend    = '0;
    runs        = lft.runs + rgt.runs;
    if (lft.max_h == rgt.max_h) begin
      if (lft.right_h == rgt.left_h && rgt.left_h == lft.max_h) begin
        runs = runs - RunW'(1);
      end
      res.max_h = lft.max_h;
      res.runs  = runs;
    end else if ($signed(lft.max_h) > $signed(rgt.max_h)) begin
      res.max_h = lft.max_h;
      res.runs  = lft.runs;
    end else begin
      res.max_h = rgt.max_h;
      res.runs  = rgt.runs;
    end
    return res;
  endfunction

endpackage

@@ rtl/core/ramrc_req_if.sv @@
// Request channel: range and signed amount to add.
// Depends on ramrc_pkg.
interface ramrc_req_if
  import ramrc_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic [PosFieldW-1:0]        range_low;
  logic [PosFieldW-1:0]        range_high;
  logic signed [DeltaW-1:0]    delta;

  modport source (output valid, output range_low, output range_high, output delta,
                  input ready);
  modport sink   (input valid, input range_low, input range_high, input delta,
                  output ready);
endinterface

@@ rtl/core/ramrc_rsp_if.sv @@
// Response channel: greatest height and number of runs at it.
// Depends on ramrc_pkg.
interface ramrc_rsp_if
  import ramrc_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic signed [HeightW-1:0]   max_height;
  logic [OutRunW-1:0]          max_run_count;

  modport source (output valid, output max_height, output max_run_count, input ready);
  modport sink   (input valid, input max_height, input max_run_count, output ready);
endinterface

@@ rtl/core/ramrc_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module ramrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/range_add_max_run_counter_unit.sv @@
// Top level of the range add / max run counter: lazy segment tree walked by a sequencer.
// Depends on ramrc_pkg, ramrc_req_if, ramrc_rsp_if and ramrc_ram.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+--------------------------------------------
//   req_i    | in  | valid / ready  | range_low[16:0], range_high[16:0], delta[15:0]
//   rsp_o    | out | valid / ready  | max_height[31:0], max_run_count[15:0]
//   cfg      | in  | cfg_we_i       | cfg_wdata_i[16:0] (position count)
//
// A request walks the tree depth first over one node memory with one write and one read
// port: each node is read (StRead) and applied (StVisit), a lazy add is pushed into its
// children through StPrd, StPwl and StPwr, each partly covered node is returned into
// (StRet) after its left and after its right child, and the root finishes in StRet.
// After reset and after each position count write, a clearing pass writes all
// 2*MAX_POSITIONS nodes, during which no request is taken.
// The result waits in an output register; the next request is taken meanwhile, and
// the walk holds at its end until that register is free.
module range_add_max_run_counter_unit
  import ramrc_pkg::*;
#(
  parameter int unsigned MAX_POSITIONS = DefMaxPositions
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ramrc_req_if.sink            req_i,
  ramrc_rsp_if.source          rsp_o,
  input  logic                 cfg_we_i,
  input  logic [PosFieldW-1:0] cfg_wdata_i
);

  localparam int unsigned NodeCount  = 2 * MAX_POSITIONS;
  localparam int unsigned NodeW      = $clog2(NodeCount);
  localparam int unsigned PosW       = $clog2(MAX_POSITIONS + 1);
  localparam int unsigned CmpW       = (PosW > PosFieldW) ? PosW : PosFieldW;
  localparam int unsigned StackDepth = $clog2(MAX_POSITIONS) + 1;
  localparam int unsigned SpW        = $clog2(StackDepth + 1);
  localparam int unsigned IdxW       = $clog2(StackDepth);

  // One frame per partially covered node on the current path.
  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [PosW-1:0]  s;
    logic [PosW-1:0]  e;
    logic             phase;  // low: left child in progress, high: right child
    node_rec_t        left;   // left child's final record
  } frame_t;

  typedef enum logic [7:0] {
    StClear = 8'b0000_0001,
    StIdle  = 8'b0000_0010,
    StRead  = 8'b0000_0100,
    StVisit = 8'b0000_1000,
    StPrd   = 8'b0001_0000,
    StPwl   = 8'b0010_0000,
    StPwr   = 8'b0100_0000,
    StRet   = 8'b1000_0000
  } state_e;

  state_e              state_q;
  logic [PosW-1:0]     num_q;
  logic [NodeW-1:0]    clr_q;
  logic [CmpW-1:0]     lo_q, hi_q;
  logic [HeightW-1:0]  add_q;
  logic [NodeW-1:0]    node_q;
  logic [PosW-1:0]     s_q, e_q;
  logic [HeightW-1:0]  push_q;
  logic                ret_mode_q;
  node_rec_t           ret_q;
  frame_t              stack_q [StackDepth];
  logic [SpW-1:0]      sp_q;
  logic                out_valid_q;
  logic [HeightW-1:0]  out_max_q;
  logic [OutRunW-1:0]  out_run_q;

  // Node memory.
  logic             ram_we;
  logic [NodeW-1:0] ram_waddr, ram_raddr;
  node_rec_t        ram_wdata, ram_rdata;

  ramrc_ram #(
    .WIDTH (NodeRecW),
    .DEPTH (NodeCount)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Top of stack.
  logic [IdxW-1:0] top_idx, push_idx;
  frame_t          top;
  assign top_idx  = IdxW'(sp_q - SpW'(1));
  assign push_idx = IdxW'(sp_q);
  assign top      = stack_q[top_idx];

  // Child addressing, shared between the visit of a node and the return to its parent.
  logic [NodeW-1:0] src_node, lc, rc;
  logic [PosW-1:0]  src_s, src_e, mid, half;
  logic [PosW:0]    span_sum, off_w;
  always_comb begin
    if (state_q == StRet) begin
      src_node = top.node;
      src_s    = top.s;
      src_e    = top.e;
    end else begin
      src_node = node_q;
      src_s    = s_q;
      src_e    = e_q;
    end
    span_sum = {1'b0, src_s} + {1'b0, src_e};
    mid      = span_sum[PosW:1];
    half     = mid - src_s + PosW'(1);
    off_w    = {half, 1'b0};
    lc       = src_node + NodeW'(1);
    rc       = src_node + NodeW'(off_w);
  end

  // Apply the node's own pending add, then classify against the request range.
  node_rec_t           applied, covered, merged;
  logic [HeightW-1:0]  full_amt, push_amt;
  logic                out_rng, full_rng, is_leaf, do_push;
  always_comb begin
    applied      = add_rec(ram_rdata, ram_rdata.pend);
    applied.pend = '0;
    covered      = add_rec(applied, add_q);
    full_amt     = ram_rdata.pend + add_q;
    out_rng      = (CmpW'(s_q) > hi_q) || (CmpW'(e_q) < lo_q);
    full_rng     = (CmpW'(s_q) >= lo_q) && (CmpW'(e_q) <= hi_q);
    is_leaf      = (s_q == e_q);
    push_amt     = (!out_rng && full_rng) ? full_amt : ram_rdata.pend;
    do_push      = (push_amt != '0) && !is_leaf;
    merged       = merge_rec(top.left, ret_q);
  end

  // Clamp the position count to 1..MAX_POSITIONS.
  logic [CmpW-1:0] cfg_ext;
  logic [PosW-1:0] num_new;
  always_comb begin
    cfg_ext = CmpW'(cfg_wdata_i);
    priority if (cfg_ext == '0) begin
      num_new = PosW'(1);
    end else if (cfg_ext > CmpW'(MAX_POSITIONS)) begin
      num_new = PosW'(MAX_POSITIONS);
    end else begin
      num_new = PosW'(cfg_ext);
    end
  end

  logic out_free, req_fire;
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == StIdle);
  assign req_fire  = req_i.valid && req_i.ready;

  // Drop the result once taken; load a new one when the root finishes.
  logic out_valid_d;
  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.valid && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (!cfg_we_i && (state_q == StRet) && (sp_q == '0) && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.max_height    = out_max_q;
  assign rsp_o.max_run_count = out_run_q;

  // Memory port steering.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node_q;
    ram_wdata = applied;
    ram_raddr = node_q;
    unique case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = NodeRecReset;
      end
      StVisit: begin
        ram_we    = out_rng || full_rng;
        ram_wdata = out_rng ? applied : covered;
        ram_raddr = lc;
      end
      StPrd: begin
        ram_raddr = lc;
      end
      StPwl: begin
        ram_we         = 1'b1;
        ram_waddr      = lc;
        ram_wdata      = ram_rdata;
        ram_wdata.pend = ram_rdata.pend + push_q;
        ram_raddr      = rc;
      end
      StPwr: begin
        ram_we         = 1'b1;
        ram_waddr      = rc;
        ram_wdata      = ram_rdata;
        ram_wdata.pend = ram_rdata.pend + push_q;
      end
      StRet: begin
        ram_we    = (sp_q != '0) && top.phase;
        ram_waddr = top.node;
        ram_wdata = merged;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      num_q       <= PosW'(MAX_POSITIONS);
      clr_q       <= '0;
      sp_q        <= '0;
      ret_mode_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        // New position count: drop the tree and clear it again.
        num_q   <= num_new;
        clr_q   <= '0;
        sp_q    <= '0;
        state_q <= StClear;
      end else begin
        unique case (state_q)
          StClear: begin
            if (clr_q == NodeW'(NodeCount - 1)) begin
              state_q <= StIdle;
            end else begin
              clr_q <= clr_q + NodeW'(1);
            end
          end
          StIdle: begin
            if (req_fire) begin
              sp_q    <= '0;
              state_q <= StRead;
            end
          end
          StRead: begin
            state_q <= StVisit;
          end
          StVisit: begin
            if (out_rng || full_rng) begin
              ret_mode_q <= 1'b1;
              state_q    <= do_push ? StPrd : StRet;
            end else begin
              ret_mode_q <= 1'b0;
              sp_q       <= sp_q + SpW'(1);
              state_q    <= do_push ? StPrd : StRead;
            end
          end
          StPrd: begin
            state_q <= StPwl;
          end
          StPwl: begin
            state_q <= StPwr;
          end
          StPwr: begin
            state_q <= ret_mode_q ? StRet : StRead;
          end
          StRet: begin
            if (sp_q == '0) begin
              // Root finished: hand the result over once the output is free.
              if (out_free) begin
                state_q <= StIdle;
              end
            end else if (!top.phase) begin
              state_q <= StRead;
            end else begin
              sp_q <= sp_q - SpW'(1);
            end
          end
          default: begin
            state_q <= StClear;
          end
        endcase
      end
    end
  end

  // Walk registers, stack and result payload.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (req_fire) begin
          lo_q   <= CmpW'(req_i.range_low);
          hi_q   <= CmpW'(req_i.range_high);
          add_q  <= HeightW'(req_i.delta);
          node_q <= '0;
          s_q    <= PosW'(1);
          e_q    <= num_q;
        end
      end
      StVisit: begin
        push_q <= push_amt;
        if (out_rng) begin
          ret_q <= applied;
        end else if (full_rng) begin
          ret_q <= covered;
        end else begin
          stack_q[push_idx] <= '{node: node_q, s: s_q, e: e_q, phase: 1'b0,
                                 left: NodeRecReset};
          if (!do_push) begin
            node_q <= lc;
            e_q    <= mid;
          end
        end
      end
      StPwr: begin
        if (!ret_mode_q) begin
          node_q <= lc;
          e_q    <= mid;
        end
      end
      StRet: begin
        if (sp_q == '0) begin
          if (out_free) begin
            out_max_q <= ret_q.max_h;
            out_run_q <= ret_q.runs[OutRunW-1:0];
          end
        end else if (!top.phase) begin
          // Left side done: hold its record, advance into the right child.
          stack_q[top_idx].left  <= ret_q;
          stack_q[top_idx].phase <= 1'b1;
          node_q <= rc;
          s_q    <= mid + PosW'(1);
          e_q    <= top.e;
        end else begin
          ret_q <= merged;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for range_add_max_run_counter_unit.
// Depends on ramrc_pkg, ramrc_req_if, ramrc_rsp_if and the unit's RTL. Drives range-add
// requests, predicts the greatest height and its run count with a lazy segment tree.
module testbench;
  import ramrc_pkg::*;

  localparam int unsigned NumPos    = DefMaxPositions;
  localparam int unsigned NumNodes  = 2 * NumPos;
  localparam int unsigned DrainWait = 1000;
  localparam longint     CycleLimit = 64'd8_000_000;

  typedef struct packed {
    logic [PosFieldW-1:0]     lo;
    logic [PosFieldW-1:0]     hi;
    logic signed [DeltaW-1:0] amount;
  } range_add_t;

  typedef struct packed {
    logic signed [HeightW-1:0] peak;
    logic [OutRunW-1:0]        peak_runs;
  } peak_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [PosFieldW-1:0] cfg_wdata_i;

  ramrc_req_if req_bus ();
  ramrc_rsp_if rsp_bus ();

  range_add_max_run_counter_unit #(.MAX_POSITIONS(NumPos)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Clock: period 10.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Height tree shadow: same node layout as the unit (root 0, left child +1,
  // right child +2*(left size)), lazy adds held per node.
  // ---------------------------------------------------------------------------
  logic [HeightW-1:0] t_max   [NumNodes];
  logic [HeightW-1:0] t_left  [NumNodes];
  logic [HeightW-1:0] t_right [NumNodes];
  logic [RunW-1:0]    t_runs  [NumNodes];
  logic [HeightW-1:0] t_pend  [NumNodes];
  int unsigned        used_positions;
  int unsigned        upd_lo, upd_hi;
  logic [HeightW-1:0] upd_amount;

  // Clamp the position count and zero every height.
  function automatic void resize_and_clear(logic [PosFieldW-1:0] count);
    int unsigned n;
    n = count;
    if (n < 1) n = 1;
    if (n > NumPos) n = NumPos;
    used_positions = n;
    for (int unsigned i = 0; i < NumNodes; i++) begin
      t_max[i]   = '0;
      t_left[i]  = '0;
      t_right[i] = '0;
      t_pend[i]  = '0;
      t_runs[i]  = RunW'(1);
    end
  endfunction

  // Apply an add to a node and hand it down lazily to both children.
  function automatic void lift_node(int unsigned nd, int unsigned s, int unsigned e,
                                    logic [HeightW-1:0] amt);
    int unsigned mid, lc, rc;
    t_max[nd]   = t_max[nd] + amt;
    t_left[nd]  = t_left[nd] + amt;
    t_right[nd] = t_right[nd] + amt;
    if (s != e) begin
      mid = (s + e) >> 1;
      lc  = nd + 1;
      rc  = nd + 2 * (mid - s + 1);
      if (lc < NumNodes) t_pend[lc] = t_pend[lc] + amt;
      if (rc < NumNodes) t_pend[rc] = t_pend[rc] + amt;
    end
  endfunction

  function automatic void walk_tree(int unsigned nd, int unsigned s, int unsigned e);
    int unsigned        mid, lc, rc;
    logic [RunW-1:0]    joined;
    logic [HeightW-1:0] held;
    if (nd >= NumNodes) return;
    if (t_pend[nd] != '0) begin
      held       = t_pend[nd];
      t_pend[nd] = '0;
      lift_node(nd, s, e, held);
    end
    if (s > upd_hi || e < upd_lo) return;
    if (s >= upd_lo && e <= upd_hi) begin
      lift_node(nd, s, e, upd_amount);
      return;
    end
    mid = (s + e) >> 1;
    lc  = nd + 1;
    rc  = nd + 2 * (mid - s + 1);
    if (rc >= NumNodes) return;
    walk_tree(lc, s, mid);
    walk_tree(rc, mid + 1, e);
    t_left[nd]  = t_left[lc];
    t_right[nd] = t_right[rc];
    if (t_max[lc] == t_max[rc]) begin
      joined = t_runs[lc] + t_runs[rc];
      // runs touching at the shared border count once
      if (t_right[lc] == t_left[rc] && t_left[rc] == t_max[lc]) joined = joined - 1'b1;
      t_max[nd]  = t_max[lc];
      t_runs[nd] = joined;
    end else if ($signed(t_max[lc]) > $signed(t_max[rc])) begin
      t_max[nd]  = t_max[lc];
      t_runs[nd] = t_runs[lc];
    end else begin
      t_max[nd]  = t_max[rc];
      t_runs[nd] = t_runs[rc];
    end
  endfunction

  function automatic peak_t apply_range_add(range_add_t r);
    peak_t p;
    upd_lo     = r.lo;
    upd_hi     = r.hi;
    upd_amount = HeightW'(r.amount);  // sign extends
    walk_tree(0, 1, used_positions);
    p.peak      = t_max[0];
    p.peak_runs = t_runs[0][OutRunW-1:0];
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Queues, idling and bookkeeping
  // ---------------------------------------------------------------------------
  range_add_t pending_q[$];
  peak_t      peak_q[$];
  int         fail_count = 0;
  bit         calm_stretch = 1'b0;   // no idling on either side while set

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Random request over the current position count: mostly well-formed ranges with small
  // amounts so that equal heights and runs form, the rest noise and odd ranges.
  function automatic range_add_t random_range_add(int unsigned n);
    range_add_t  r;
    int unsigned a, b, k;
    k = $urandom_range(0, 99);
    if (k < 78) begin
      a = $urandom_range(1, n);
      b = $urandom_range(1, n);
      r.lo = PosFieldW'(a < b ? a : b);
      r.hi = PosFieldW'(a < b ? b : a);
    end else if (k < 88) begin
      r.lo = PosFieldW'($urandom);
      r.hi = PosFieldW'($urandom);
    end else if (k < 95) begin
      // reach past either end of the used positions
      r.lo = PosFieldW'($urandom_range(0, 2));
      r.hi = PosFieldW'($urandom_range(n, n + 3));
    end else begin
      a = $urandom_range(1, n);
      r.lo = PosFieldW'(a + 1);
      r.hi = PosFieldW'(a);
    end
    if ($urandom_range(0, 9) == 0) r.amount = DeltaW'($urandom);
    else r.amount = DeltaW'($signed($urandom_range(0, 6)) - 3);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: predict on acceptance, then present the next request or idle.
  // ---------------------------------------------------------------------------
  int unsigned req_gap;
  int unsigned sent_count;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid      <= 1'b0;
      req_bus.range_low  <= '0;
      req_bus.range_high <= '0;
      req_bus.delta      <= '0;
      req_gap            <= 0;
      sent_count         <= 0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        peak_q.push_back(apply_range_add('{req_bus.range_low, req_bus.range_high,
                                           req_bus.delta}));
      end
      if (req_bus.valid && !req_bus.ready) begin
        // hold the request until taken
      end else if (req_gap > 0) begin
        req_gap       <= req_gap - 1;
        req_bus.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        range_add_t nxt;
        nxt = pending_q.pop_front();
        req_bus.valid      <= 1'b1;
        req_bus.range_low  <= nxt.lo;
        req_bus.range_high <= nxt.hi;
        req_bus.delta      <= nxt.amount;
        req_gap            <= idle_len();
        sent_count         <= sent_count + 1;
        // toggle calm stretches now and then
        if (sent_count % 64 == 63) calm_stretch = ($urandom_range(0, 3) == 0);
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response monitor: random back-pressure, compare against the oldest prediction.
  // ---------------------------------------------------------------------------
  int unsigned rsp_stall;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      rsp_stall     <= 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (peak_q.size() == 0) begin
          $error("unexpected response: max_height %0d max_run_count %0d",
                 rsp_bus.max_height, rsp_bus.max_run_count);
          fail_count++;
        end else begin
          peak_t want;
          want = peak_q.pop_front();
          if (rsp_bus.max_height !== want.peak) begin
            $error("max_height: expected %0d, got %0d", want.peak, rsp_bus.max_height);
            fail_count++;
          end
          if (rsp_bus.max_run_count !== want.peak_runs) begin
            $error("max_run_count: expected %0d, got %0d", want.peak_runs,
                   rsp_bus.max_run_count);
            fail_count++;
          end
        end
      end
      if (rsp_stall > 0) begin
        rsp_stall     <= rsp_stall - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
        rsp_stall     <= idle_len();
      end
    end
  end

  // Watchdog: the clearing passes and slow walks fit well inside this.
  longint cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("range_add_max_run_counter_unit regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed and random requests at full size, then random phases over several
  // position counts, each count written only once the unit has drained.
  // ---------------------------------------------------------------------------
  task automatic drain_unit();
    while (pending_q.size() > 0 || req_bus.valid || peak_q.size() > 0) @(posedge clk_i);
    // a request may still be walking after the last response went out
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_positions(logic [PosFieldW-1:0] count);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    resize_and_clear(count);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic queue_directed();
    range_add_t d[$];
    d.push_back('{17'd1, 17'd65536, 16'sd5});       // whole row
    d.push_back('{17'd1, 17'd1, 16'sd7});            // first position alone
    d.push_back('{17'd65536, 17'd65536, 16'sd7});    // last position alone: two runs
    d.push_back('{17'd2, 17'd65535, 16'sd7});        // middle joins both ends
    d.push_back('{17'd9, 17'd3, 16'sd100});          // low above high: no change
    d.push_back('{17'd0, 17'd4, 16'sd1});            // starts below position 1
    d.push_back('{17'd65530, 17'h1FFFF, 16'sd1});    // runs past the end
    d.push_back('{17'h1FFFF, 17'h1FFFF, 16'sd9});    // wholly outside
    d.push_back('{17'd1, 17'd65536, -16'sd32768});   // most negative amount
    d.push_back('{17'd1, 17'd65536, 16'sd32767});    // most positive amount
    d.push_back('{17'd100, 17'd200, 16'sd3});
    d.push_back('{17'd300, 17'd400, 16'sd3});
    d.push_back('{17'd201, 17'd299, 16'sd3});        // bridge two runs into one
    d.push_back('{17'd250, 17'd250, -16'sd1});       // split the run again
    d.push_back('{17'd1, 17'd65536, 16'sd0});        // zero amount
    d.push_back('{17'd32768, 17'd32769, 16'sd50});   // across the root border
    d.push_back('{17'd32769, 17'd32769, -16'sd1});
    d.push_back('{17'd0, 17'd0, 16'sd1});            // position zero only
    foreach (d[i]) pending_q.push_back(d[i]);
  endtask

  task automatic queue_random(int unsigned count);
    repeat (count) pending_q.push_back(random_range_add(used_positions));
  endtask

  initial begin
    logic [PosFieldW-1:0] sizes[$];
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    resize_and_clear(PosFieldW'(NumPos));
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_directed();
    queue_random(232);
    drain_unit();

    // 0 is taken as one position, all ones as the maximum
    sizes = '{17'd0, 17'd6, 17'h1FFFF, 17'd37, 17'd1, 17'd65536};
    foreach (sizes[i]) begin
      write_positions(sizes[i]);
      queue_random(sizes[i] == 17'd0 || sizes[i] == 17'd1 ? 60 : 170);
      drain_unit();
    end

    if (fail_count == 0) begin
      $display("range_add_max_run_counter_unit regression: pass");
    end else begin
      $display("range_add_max_run_counter_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ range_add_max_run_counter_unit.f @@
rtl/core/ramrc_pkg.sv
rtl/core/ramrc_req_if.sv
rtl/core/ramrc_rsp_if.sv
rtl/core/ramrc_ram.sv
rtl/core/range_add_max_run_counter_unit.sv
verif/testbench.sv
